// ===== rtl/core/trnl_pkg.sv =====
// ----------------------------------------------------------------------------
// trnl_pkg
// Types and constants shared by the ring look-up controller and datapath.
// ----------------------------------------------------------------------------
package trnl_pkg;

   localparam int ANGLE_W    = 16;
   localparam int ROW_FIELDS = 8;
   localparam int SLOT_W     = 5;
   localparam int CSR_W      = 6;
   localparam int RESET_LEN  = 30;

   localparam logic OP_ADD    = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   typedef logic [ROW_FIELDS-1:0][ANGLE_W-1:0] row_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_FIRST,
      ST_COMPARE,
      ST_ROW,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic cfg_write;
      logic add;
      logic lookup;
      logic fetch;
      logic shift;
      logic hit;
   } cmd_type;

   typedef struct packed {
      logic short_ring;
      logic hit;
      logic last_pair;
   } status_type;

endpackage

// ===== rtl/core/timestamped_ring_nearest_lookup.sv =====
// ----------------------------------------------------------------------------
// timestamped_ring_nearest_lookup
// Ring of timestamped joint rows with nearest-entry look-up by timestamp.
//
//   channel   ports                         handshake
//   request   req_operation/stamp/angle_*   start & !busy
//   response  rsp_found/slot/row_*          rsp_valid, one cycle, no stall
//   config    csr_data (ring length)        csr_valid & csr_ready
//
// Add: taken while idle, busy stays low.
// Look-up: busy until the response; with fewer than two entries it skips
// the walk, else the stamp memory is walked one entry a cycle.
// Reset is synchronous: pointer, wrap flag and length (30) are set, the ring
// memories are not cleared. The response cannot be stalled.
// ----------------------------------------------------------------------------
module timestamped_ring_nearest_lookup #(
   parameter int MAX_ENTRIES = 32,
   parameter int NUM_JOINTS  = 8,
   parameter int STAMP_BITS  = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_operation,
   input  logic [STAMP_BITS-1:0]       req_stamp,
   input  logic [trnl_pkg::ANGLE_W-1:0] req_angle_0,
   input  logic [trnl_pkg::ANGLE_W-1:0] req_angle_1,
   input  logic [trnl_pkg::ANGLE_W-1:0] req_angle_2,
   input  logic [trnl_pkg::ANGLE_W-1:0] req_angle_3,
   input  logic [trnl_pkg::ANGLE_W-1:0] req_angle_4,
   input  logic [trnl_pkg::ANGLE_W-1:0] req_angle_5,
   input  logic [trnl_pkg::ANGLE_W-1:0] req_angle_6,
   input  logic [trnl_pkg::ANGLE_W-1:0] req_angle_7,
   output logic                        rsp_valid,
   output logic                        rsp_found,
   output logic [trnl_pkg::SLOT_W-1:0] rsp_slot,
   output logic [trnl_pkg::ANGLE_W-1:0] rsp_row_0,
   output logic [trnl_pkg::ANGLE_W-1:0] rsp_row_1,
   output logic [trnl_pkg::ANGLE_W-1:0] rsp_row_2,
   output logic [trnl_pkg::ANGLE_W-1:0] rsp_row_3,
   output logic [trnl_pkg::ANGLE_W-1:0] rsp_row_4,
   output logic [trnl_pkg::ANGLE_W-1:0] rsp_row_5,
   output logic [trnl_pkg::ANGLE_W-1:0] rsp_row_6,
   output logic [trnl_pkg::ANGLE_W-1:0] rsp_row_7,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [trnl_pkg::CSR_W-1:0]  csr_data
);
   import trnl_pkg::*;

   cmd_type    cmd;
   status_type status;
   row_type    req_row;
   row_type    rsp_row;

   assign req_row = {req_angle_7, req_angle_6, req_angle_5, req_angle_4,
                     req_angle_3, req_angle_2, req_angle_1, req_angle_0};

   assign rsp_row_0 = rsp_row[0];
   assign rsp_row_1 = rsp_row[1];
   assign rsp_row_2 = rsp_row[2];
   assign rsp_row_3 = rsp_row[3];
   assign rsp_row_4 = rsp_row[4];
   assign rsp_row_5 = rsp_row[5];
   assign rsp_row_6 = rsp_row[6];
   assign rsp_row_7 = rsp_row[7];

   trnl_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_operation),
      .csr_valid     (csr_valid),
      .status        (status),
      .busy          (busy),
      .csr_ready     (csr_ready),
      .rsp_valid     (rsp_valid),
      .cmd           (cmd)
   );

   trnl_datapath #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .NUM_JOINTS  (NUM_JOINTS),
      .STAMP_BITS  (STAMP_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_stamp (req_stamp),
      .req_row   (req_row),
      .csr_data  (csr_data),
      .rsp_found (rsp_found),
      .rsp_slot  (rsp_slot),
      .rsp_row   (rsp_row)
   );

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held longer than one cycle");

   a_add_no_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_operation == OP_ADD) |=> !busy)
      else $error("add item left the block busy");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_slot == '0 && rsp_row == '0))
      else $error("not-found response carries nonzero fields");

   a_lookup_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_operation == OP_LOOKUP) |=> (busy && !rsp_valid) || rsp_valid)
      else $error("look-up item did not start a search or respond");

endmodule

// ===== rtl/core/trnl_ctrl.sv =====
// ----------------------------------------------------------------------------
// trnl_ctrl
// Sequencer for add, search walk, row read and response strobe.
// ----------------------------------------------------------------------------
module trnl_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                req_operation,
   input  logic                csr_valid,
   input  trnl_pkg::status_type status,
   output logic                busy,
   output logic                csr_ready,
   output logic                rsp_valid,
   output trnl_pkg::cmd_type   cmd
);
   import trnl_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      busy      = 1'b1;
      csr_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy          = 1'b0;
            csr_ready     = 1'b1;
            cmd.cfg_write = csr_valid;
            if (start) begin
               if (req_operation == OP_ADD) begin
                  cmd.add = 1'b1;
               end else begin
                  cmd.lookup = 1'b1;
                  state_in   = status.short_ring ? ST_RESPOND : ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            cmd.fetch = 1'b1;
            state_in  = ST_FIRST;
         end
         ST_FIRST: begin
            cmd.fetch = 1'b1;
            cmd.shift = 1'b1;
            state_in  = ST_COMPARE;
         end
         ST_COMPARE: begin
            if (status.hit) begin
               cmd.hit  = 1'b1;
               state_in = ST_ROW;
            end else if (status.last_pair) begin
               state_in = ST_RESPOND;
            end else begin
               cmd.fetch = 1'b1;
               cmd.shift = 1'b1;
            end
         end
         ST_ROW: begin
            state_in = ST_RESPOND;
         end
         ST_RESPOND: begin
            rsp_valid = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/trnl_datapath.sv =====
// ----------------------------------------------------------------------------
// trnl_datapath
// Ring storage, write pointer, pair compare and result registers.
// ----------------------------------------------------------------------------
module trnl_datapath #(
   parameter int MAX_ENTRIES = 32,
   parameter int NUM_JOINTS  = 8,
   parameter int STAMP_BITS  = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  trnl_pkg::cmd_type              cmd,
   output trnl_pkg::status_type           status,
   input  logic [STAMP_BITS-1:0]          req_stamp,
   input  trnl_pkg::row_type              req_row,
   input  logic [trnl_pkg::CSR_W-1:0]     csr_data,
   output logic                           rsp_found,
   output logic [trnl_pkg::SLOT_W-1:0]    rsp_slot,
   output trnl_pkg::row_type              rsp_row
);
   import trnl_pkg::*;

   localparam int IDX_W     = $clog2(MAX_ENTRIES);
   localparam int CNT_W     = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W     = (CNT_W > CSR_W) ? CNT_W : CSR_W;
   localparam int LEN_RESET = (RESET_LEN > MAX_ENTRIES) ? MAX_ENTRIES : RESET_LEN;

   typedef logic [NUM_JOINTS-1:0][ANGLE_W-1:0] joints_type;

   logic [STAMP_BITS-1:0] stamp_mem [MAX_ENTRIES];
   joints_type            row_mem   [MAX_ENTRIES];

   logic [CNT_W-1:0]      len_ff,     len_in;
   logic [IDX_W-1:0]      wp_ff,      wp_in;
   logic                  wrapped_ff, wrapped_in;
   logic                  found_ff,   found_in;

   logic [IDX_W-1:0]      addr_ff;
   logic [IDX_W-1:0]      data_idx_ff;
   logic [IDX_W-1:0]      later_idx_ff;
   logic [IDX_W-1:0]      pick_ff;
   logic [STAMP_BITS-1:0] data_ff;
   logic [STAMP_BITS-1:0] later_ff;
   logic [STAMP_BITS-1:0] query_ff;
   logic [CNT_W-1:0]      pairs_ff;
   joints_type            row_q_ff;

   logic [IDX_W-1:0]      len_last;
   logic [CNT_W-1:0]      count;
   logic [CNT_W-1:0]      wp_next;
   logic [CMP_W-1:0]      csr_wide;
   logic [CMP_W-1:0]      csr_clamped;
   logic                  pick_later;
   logic [IDX_W-1:0]      wp_prev;
   logic [IDX_W-1:0]      addr_prev;

   assign len_last  = IDX_W'(len_ff - CNT_W'(1));
   assign count     = wrapped_ff ? len_ff : CNT_W'(wp_ff);
   assign wp_next   = CNT_W'(wp_ff) + CNT_W'(1);
   assign wp_prev   = (wp_ff == '0) ? len_last : wp_ff - IDX_W'(1);
   assign addr_prev = (addr_ff == '0) ? len_last : addr_ff - IDX_W'(1);

   assign csr_wide = CMP_W'(csr_data);
   always_comb begin
      if (csr_wide < CMP_W'(2)) begin
         csr_clamped = CMP_W'(2);
      end else if (csr_wide > CMP_W'(MAX_ENTRIES)) begin
         csr_clamped = CMP_W'(MAX_ENTRIES);
      end else begin
         csr_clamped = csr_wide;
      end
   end

   // later_ff holds the newer stamp of the pair, data_ff the older one
   assign pick_later       = (query_ff - data_ff) > (later_ff - query_ff);
   assign status.hit       = (later_ff >= query_ff) && (data_ff <= query_ff);
   assign status.last_pair = (pairs_ff == '0);
   assign status.short_ring = (count < CNT_W'(2));

   always_comb begin
      len_in     = len_ff;
      wp_in      = wp_ff;
      wrapped_in = wrapped_ff;
      found_in   = found_ff;
      if (cmd.add) begin
         if (wp_next >= len_ff) begin
            wp_in      = '0;
            wrapped_in = 1'b1;
         end else begin
            wp_in = IDX_W'(wp_next);
         end
      end
      if (cmd.cfg_write) begin
         len_in     = CNT_W'(csr_clamped);
         wp_in      = '0;
         wrapped_in = 1'b0;
      end
      if (cmd.lookup) begin
         found_in = 1'b0;
      end
      if (cmd.hit) begin
         found_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff     <= CNT_W'(LEN_RESET);
         wp_ff      <= '0;
         wrapped_ff <= 1'b0;
         found_ff   <= 1'b0;
      end else begin
         len_ff     <= len_in;
         wp_ff      <= wp_in;
         wrapped_ff <= wrapped_in;
         found_ff   <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.add) begin
         stamp_mem[wp_ff] <= req_stamp;
         for (int j = 0; j < NUM_JOINTS; j++) begin
            row_mem[wp_ff][j] <= req_row[j];
         end
      end
      row_q_ff <= row_mem[pick_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         query_ff <= req_stamp;
         addr_ff  <= wp_prev;
         pairs_ff <= count - CNT_W'(1);
      end
      if (cmd.fetch) begin
         data_ff     <= stamp_mem[addr_ff];
         data_idx_ff <= addr_ff;
         addr_ff     <= addr_prev;
      end
      if (cmd.shift) begin
         later_ff     <= data_ff;
         later_idx_ff <= data_idx_ff;
         pairs_ff     <= pairs_ff - CNT_W'(1);
      end
      if (cmd.hit) begin
         pick_ff <= pick_later ? later_idx_ff : data_idx_ff;
      end
   end

   assign rsp_found = found_ff;
   assign rsp_slot  = found_ff ? SLOT_W'(pick_ff) : '0;

   for (genvar j = 0; j < ROW_FIELDS; j++) begin : g_row
      if (j < NUM_JOINTS) begin : g_used
         assign rsp_row[j] = found_ff ? row_q_ff[j] : '0;
      end else begin : g_unused
         assign rsp_row[j] = '0;
      end
   end

endmodule
